// ----- rtl/key_frequency_min_max_table_macros.svh -----
// Assertion macros for the key frequency table checker.
// Included by the checker file only.
`ifndef KEY_FREQUENCY_MIN_MAX_TABLE_MACROS_SVH
`define KEY_FREQUENCY_MIN_MAX_TABLE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define KFT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define KFT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/kfmm_pkg.sv -----
// Package for the key frequency table: sizes and status codes.
// No dependencies.
`default_nettype none
package kfmm_pkg;
  localparam int KEY_SLOTS   = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int COUNT_WIDTH = 16;
  localparam int SLOT_W      = $clog2(KEY_SLOTS);
  localparam int STAMP_W     = 64;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_SAT    = 2'd3;

  localparam logic REQ_INC = 1'b0;
  localparam logic REQ_DEC = 1'b1;
endpackage
`default_nettype wire

// ----- rtl/key_frequency_min_max_table.sv -----
// Key frequency table with max/min count key reporting, top level.
// Depends on kfmm_pkg.
//
// One request at a time. A request walks every slot of the table memory
// (one synchronous read a cycle) to find the key and a free slot, writes the
// changed entry back, then walks the table a second time to pick the max and
// min keys. The result sits in an output register; the next request is taken
// only once it has been delivered.
`default_nettype none
module key_frequency_min_max_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic [31:0] in_key,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_not_empty,
  output logic [31:0]      out_max_key,
  output logic [31:0]      out_min_key,
  output logic [15:0]      out_new_count,
  output logic [1:0]       out_status
);
  localparam int SW = kfmm_pkg::SLOT_W;
  localparam int KW = kfmm_pkg::KEY_WIDTH;
  localparam int CW = kfmm_pkg::COUNT_WIDTH;
  localparam int TW = kfmm_pkg::STAMP_W;
  localparam int EW = KW + CW + TW;
  localparam logic [CW-1:0] CMAX = {CW{1'b1}};
  localparam logic [SW:0] LAST = (SW+1)'(kfmm_pkg::KEY_SLOTS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_SEL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // Slot memory: key, count, stamp per entry; used bits in flops.
  logic [EW-1:0] mem [kfmm_pkg::KEY_SLOTS];
  logic [EW-1:0] rd_q;
  logic [kfmm_pkg::KEY_SLOTS-1:0] used_r;

  logic [2:0]    state_r;
  logic [SW:0]   idx_r;
  logic          rvld_r;
  logic [SW-1:0] ridx_r;
  logic          req_r;
  logic [KW-1:0] key_r;
  logic          hit_r, free_ok_r;
  logic [SW-1:0] hit_slot_r, free_slot_r;
  logic [CW-1:0] hit_cnt_r;
  logic [TW-1:0] clock_r;
  logic          mx_ok_r, mn_ok_r;
  logic [KW-1:0] mx_key_r, mn_key_r;
  logic [CW-1:0] mx_cnt_r, mn_cnt_r;
  logic [TW-1:0] mx_ts_r, mn_ts_r;
  logic [CW-1:0] ncnt_r;
  logic [1:0]    stat_r;

  logic          we;
  logic [SW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [SW-1:0] raddr;
  logic [KW-1:0] e_key;
  logic [CW-1:0] e_cnt;
  logic [TW-1:0] e_ts;

  assign e_key = rd_q[EW-1 -: KW];
  assign e_cnt = rd_q[TW +: CW];
  assign e_ts  = rd_q[TW-1:0];
  assign raddr = idx_r[SW-1:0];
  assign in_ready = (state_r == S_IDLE);

  // Memory port: one write, one registered read.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  // Write-back of the changed entry.
  always_comb begin
    we = 1'b0;
    waddr = hit_slot_r;
    wdata = {key_r, hit_cnt_r, clock_r};
    if (state_r == S_UPD) begin
      if (req_r == kfmm_pkg::REQ_INC) begin
        if (hit_r) begin
          we = (hit_cnt_r != CMAX);
          wdata = {key_r, hit_cnt_r + CW'(1), clock_r};
        end else begin
          we = free_ok_r;
          waddr = free_slot_r;
          wdata = {key_r, CW'(1), clock_r};
        end
      end else begin
        we = hit_r && (hit_cnt_r > CW'(1));
        wdata = {key_r, hit_cnt_r - CW'(1), clock_r};
      end
    end
  end

  // Sequencer: scan for key, update, scan for max/min, deliver.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      used_r    <= '0;
      clock_r   <= '0;
      rvld_r    <= 1'b0;
      out_valid <= 1'b0;
      idx_r     <= '0;
    end else begin
      ridx_r <= raddr;
      case (state_r)
        S_IDLE: begin
          rvld_r <= 1'b0;
          if (in_valid) begin
            req_r     <= in_req_type;
            key_r     <= in_key;
            hit_r     <= 1'b0;
            free_ok_r <= 1'b0;
            idx_r     <= '0;
            state_r   <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Issue reads; compare the word read last cycle.
          rvld_r <= (idx_r <= LAST);
          if (idx_r <= LAST) begin
            idx_r  <= idx_r + 1'b1;
          end
          if (rvld_r) begin
            if (used_r[ridx_r] && e_key == key_r) begin
              hit_r      <= 1'b1;
              hit_slot_r <= ridx_r;
              hit_cnt_r  <= e_cnt;
            end
            if (!used_r[ridx_r] && !free_ok_r) begin
              free_ok_r   <= 1'b1;
              free_slot_r <= ridx_r;
            end
          end
          if (idx_r > LAST && !rvld_r) state_r <= S_UPD;
        end
        S_UPD: begin
          rvld_r <= 1'b0;
          if (req_r == kfmm_pkg::REQ_INC) begin
            if (hit_r) begin
              if (hit_cnt_r == CMAX) begin
                stat_r <= kfmm_pkg::ST_SAT;
                ncnt_r <= hit_cnt_r;
              end else begin
                stat_r  <= kfmm_pkg::ST_DONE;
                ncnt_r  <= hit_cnt_r + CW'(1);
                clock_r <= clock_r + TW'(1);
              end
            end else if (free_ok_r) begin
              used_r[free_slot_r] <= 1'b1;
              stat_r  <= kfmm_pkg::ST_DONE;
              ncnt_r  <= CW'(1);
              clock_r <= clock_r + TW'(1);
            end else begin
              stat_r <= kfmm_pkg::ST_FULL;
              ncnt_r <= '0;
            end
          end else begin
            if (!hit_r) begin
              stat_r <= kfmm_pkg::ST_ABSENT;
              ncnt_r <= '0;
            end else if (hit_cnt_r <= CW'(1)) begin
              used_r[hit_slot_r] <= 1'b0;
              stat_r <= kfmm_pkg::ST_DONE;
              ncnt_r <= '0;
            end else begin
              stat_r  <= kfmm_pkg::ST_DONE;
              ncnt_r  <= hit_cnt_r - CW'(1);
              clock_r <= clock_r + TW'(1);
            end
          end
          mx_ok_r <= 1'b0;
          mn_ok_r <= 1'b0;
          idx_r   <= '0;
          state_r <= S_SEL;
        end
        S_SEL: begin
          rvld_r <= (idx_r <= LAST);
          if (idx_r <= LAST) begin
            idx_r  <= idx_r + 1'b1;
          end
          if (rvld_r && used_r[ridx_r]) begin
            if (!mx_ok_r || e_cnt > mx_cnt_r ||
                (e_cnt == mx_cnt_r && e_ts > mx_ts_r)) begin
              mx_ok_r <= 1'b1;
              mx_key_r <= e_key;
              mx_cnt_r <= e_cnt;
              mx_ts_r  <= e_ts;
            end
            if (!mn_ok_r || e_cnt < mn_cnt_r ||
                (e_cnt == mn_cnt_r && e_ts > mn_ts_r)) begin
              mn_ok_r <= 1'b1;
              mn_key_r <= e_key;
              mn_cnt_r <= e_cnt;
              mn_ts_r  <= e_ts;
            end
          end
          if (idx_r > LAST && !rvld_r) begin
            out_valid <= 1'b1;
            state_r   <= S_OUT;
          end
        end
        S_OUT: begin
          rvld_r <= 1'b0;
          if (out_ready) begin
            out_valid <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
        default: begin
          rvld_r  <= 1'b0;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_not_empty = mx_ok_r;
  assign out_max_key   = mx_ok_r ? mx_key_r : '0;
  assign out_min_key   = mn_ok_r ? mn_key_r : '0;
  assign out_new_count = ncnt_r;
  assign out_status    = stat_r;
endmodule
`default_nettype wire

// ----- rtl/kfmm_checker.sv -----
// Port-level checker for the key frequency table, with its bind.
// Depends on kfmm_pkg and the macros header.
`default_nettype none
`include "key_frequency_min_max_table_macros.svh"
module kfmm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_not_empty,
  input wire logic [31:0] out_max_key,
  input wire logic [31:0] out_min_key,
  input wire logic [15:0] out_new_count,
  input wire logic [1:0]  out_status
);
  // Take no new word while a result waits.
  `KFT_ASSERT_IMP(a_busy, out_valid, !in_ready, "input taken while result pending")
  // An empty table reports zero keys.
  `KFT_ASSERT_IMP(a_empty, out_valid && !out_not_empty,
    out_max_key == 32'd0 && out_min_key == 32'd0, "empty table with nonzero key")
  // Absent or dropped requests give count zero.
  `KFT_ASSERT_IMP(a_zero, out_valid && (out_status == kfmm_pkg::ST_ABSENT ||
    out_status == kfmm_pkg::ST_FULL), out_new_count == 16'd0, "count on failed request")
  // A nonzero new count means the table holds a key.
  `KFT_ASSERT_IMP(a_held, out_valid && out_new_count != 16'd0, out_not_empty,
    "count without held key")
  // No result the cycle after an input word is taken.
  `KFT_ASSERT_NXT(a_lat, in_valid && in_ready, !out_valid, "result too early")
endmodule

bind key_frequency_min_max_table kfmm_checker u_kfmm_checker (.*);
`default_nettype wire

// ----- bench/key_frequency_min_max_table_tb.sv -----
// Testbench for key_frequency_min_max_table: random and directed count requests,
// checked against an in-bench count table model. Depends on kfmm_pkg and the RTL.
`default_nettype none
module key_frequency_min_max_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        not_empty;
    logic [31:0] max_key;
    logic [31:0] min_key;
    logic [15:0] new_count;
    logic [1:0]  status;
  } tally_word_t;

  int error_count = 0;

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Count table model and queue of expected result words.
  class tally_scoreboard;
    logic [31:0] key_of[kfmm_pkg::KEY_SLOTS];
    bit          used[kfmm_pkg::KEY_SLOTS];
    logic [15:0] cnt[kfmm_pkg::KEY_SLOTS];
    logic [63:0] stamp[kfmm_pkg::KEY_SLOTS];
    logic [63:0] clock_now;
    tally_word_t pending[$];

    function new();
      foreach (used[i]) used[i] = 0;
      clock_now = 0;
    endfunction

    function int held_count();
      int n;
      n = 0;
      foreach (used[i]) if (used[i]) n++;
      return n;
    endfunction

    function logic [15:0] count_of(logic [31:0] k);
      foreach (used[i]) if (used[i] && key_of[i] == k) return cnt[i];
      return 0;
    endfunction

    // Apply one request and queue the word it should produce.
    function void note_request(logic req, logic [31:0] k);
      tally_word_t w;
      int s, imax, imin;
      s = -1; imax = -1; imin = -1;
      w = '0;
      w.status = kfmm_pkg::ST_DONE;
      foreach (used[i]) if (s < 0 && used[i] && key_of[i] == k) s = i;
      if (req == kfmm_pkg::REQ_INC) begin
        if (s >= 0) begin
          if (cnt[s] == 16'hFFFF) begin
            w.status = kfmm_pkg::ST_SAT;
          end else begin
            cnt[s]++; stamp[s] = clock_now++;
          end
          w.new_count = cnt[s];
        end else begin
          foreach (used[i]) if (s < 0 && !used[i]) s = i;
          if (s < 0) begin
            w.status = kfmm_pkg::ST_FULL;
          end else begin
            used[s] = 1; key_of[s] = k; cnt[s] = 1; stamp[s] = clock_now++;
            w.new_count = 1;
          end
        end
      end else begin
        if (s < 0) begin
          w.status = kfmm_pkg::ST_ABSENT;
        end else if (cnt[s] <= 1) begin
          used[s] = 0;
        end else begin
          cnt[s]--; stamp[s] = clock_now++;
          w.new_count = cnt[s];
        end
      end
      foreach (used[i]) begin
        if (!used[i]) continue;
        if (imax < 0 || cnt[i] > cnt[imax] ||
            (cnt[i] == cnt[imax] && stamp[i] > stamp[imax])) imax = i;
        if (imin < 0 || cnt[i] < cnt[imin] ||
            (cnt[i] == cnt[imin] && stamp[i] > stamp[imin])) imin = i;
      end
      w.not_empty = (imax >= 0);
      if (imax >= 0) begin
        w.max_key = key_of[imax];
        w.min_key = key_of[imin];
      end
      pending.push_back(w);
    endfunction

    // Compare an accepted result word with the oldest expectation.
    task check_result(tally_word_t got);
      tally_word_t want;
      if (pending.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        error_count++;
        return;
      end
      want = pending.pop_front();
      if (got.not_empty !== want.not_empty)
        report_mismatch("not_empty", 32'(got.not_empty), 32'(want.not_empty));
      if (got.max_key !== want.max_key) report_mismatch("max_key", got.max_key, want.max_key);
      if (got.min_key !== want.min_key) report_mismatch("min_key", got.min_key, want.min_key);
      if (got.new_count !== want.new_count)
        report_mismatch("new_count", 32'(got.new_count), 32'(want.new_count));
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        in_req_type = 0;
  logic [31:0] in_key = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        out_not_empty;
  logic [31:0] out_max_key, out_min_key;
  logic [15:0] out_new_count;
  logic [1:0]  out_status;
  bit          stim_done = 0;
  logic [31:0] key_pool[8];

  tally_scoreboard board = new();

  key_frequency_min_max_table u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_key(in_key),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_not_empty(out_not_empty), .out_max_key(out_max_key),
    .out_min_key(out_min_key), .out_new_count(out_new_count), .out_status(out_status)
  );

  always #10 clk = ~clk;

  // Offer one request word after a random gap (none if no_gap is set) and hold it until taken.
  task automatic send_request(input logic req, input logic [31:0] k, input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1; in_req_type <= req; in_key <= k;
    do @(posedge clk); while (!in_ready);
    board.note_request(req, k);
  endtask

  // Drop valid and hold off until every expected word has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  // Sample results at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result({out_not_empty, out_max_key, out_min_key, out_new_count, out_status});
  end

  // Receiver: random stall per word, with calm stretches.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        out_ready <= 0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Stimulus: directed cases, then random traffic.
  initial begin
    int pick;
    logic [31:0] k;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // Empty table, absent decrement, extremes of the key.
    send_request(kfmm_pkg::REQ_DEC, 32'h0);
    send_request(kfmm_pkg::REQ_INC, 32'hFFFF_FFFF);
    send_request(kfmm_pkg::REQ_INC, 32'h0);
    send_request(kfmm_pkg::REQ_INC, 32'h0);
    send_request(kfmm_pkg::REQ_INC, 32'hA5A5_5A5A);
    send_request(kfmm_pkg::REQ_DEC, 32'h0);
    send_request(kfmm_pkg::REQ_DEC, 32'hFFFF_FFFF);
    send_request(kfmm_pkg::REQ_DEC, 32'hFFFF_FFFF);
    send_request(kfmm_pkg::REQ_DEC, 32'h0);
    send_request(kfmm_pkg::REQ_DEC, 32'hA5A5_5A5A);
    // Fill the table and overflow it.
    for (int i = 0; i < kfmm_pkg::KEY_SLOTS + 2; i++)
      send_request(kfmm_pkg::REQ_INC, 32'h100 + i, 1);
    send_request(kfmm_pkg::REQ_DEC, 32'h105);
    send_request(kfmm_pkg::REQ_INC, 32'hDEAD_BEEF);
    drain_results();
    for (int i = 0; i < kfmm_pkg::KEY_SLOTS + 2; i++)
      send_request(kfmm_pkg::REQ_DEC, 32'h100 + i, 1);
    send_request(kfmm_pkg::REQ_DEC, 32'hDEAD_BEEF);
    // Raise one key well above the rest with back-to-back words.
    for (int i = 0; i < 40; i++) send_request(kfmm_pkg::REQ_INC, 32'h5555_AAAA, 1);
    send_request(kfmm_pkg::REQ_INC, 32'h5555_AAAA);
    send_request(kfmm_pkg::REQ_INC, 32'h1);
    send_request(kfmm_pkg::REQ_DEC, 32'h5555_AAAA);
    send_request(kfmm_pkg::REQ_INC, 32'h5555_AAAA);
    drain_results();
    // Random traffic over a small hot pool and wide random keys.
    foreach (key_pool[i]) key_pool[i] = $urandom();
    for (int n = 0; n < 1500; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) k = key_pool[$urandom_range(0, 7)];
      else if (pick < 9) k = 32'h200 + $urandom_range(0, 80);
      else k = $urandom();
      if (board.held_count() >= kfmm_pkg::KEY_SLOTS - 2 && $urandom_range(0, 1)) begin
        send_request(kfmm_pkg::REQ_DEC, k);
      end else begin
        send_request($urandom_range(0, 9) < 6 ? kfmm_pkg::REQ_INC : kfmm_pkg::REQ_DEC, k);
      end
      if (n == 800) drain_results();
    end
    drain_results();
    stim_done = 1;
  end

  // Finish once the queue has drained.
  initial begin
    wait (stim_done);
    repeat (300) @(negedge clk);
    if (error_count == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #40ms;
    $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/kfmm_pkg.sv
rtl/key_frequency_min_max_table.sv
rtl/kfmm_checker.sv
bench/key_frequency_min_max_table_tb.sv
